// ===== hw/rtl/chrd_pkg.sv =====
// Shared types, chord shape table and helpers for the chord template recognizer.
`default_nettype none

package chrd_pkg;

  localparam int unsigned NumClasses = 12;
  localparam int unsigned NumShapes  = 13;
  localparam int unsigned RootW      = 4;
  localparam int unsigned QualW      = 4;

  // Chord shapes as pitch-class sets relative to the root, in template order.
  localparam logic [NumClasses-1:0] CHORD_SHAPES [NumShapes] = '{
    12'h091, // major
    12'h089, // minor
    12'h049, // diminished
    12'h111, // augmented
    12'h085, // sus2
    12'h0A1, // sus4
    12'h891, // major 7th
    12'h489, // minor 7th
    12'h491, // dominant 7th
    12'h249, // diminished 7th
    12'h449, // half-diminished
    12'h095, // add9
    12'h495  // dominant 9th
  };

  localparam logic [RootW-1:0] LAST_ROOT = RootW'(NumClasses - 1);

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_CHORD  = 2'd2,
    KIND_UNREC  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ctrl_state_e;

  typedef struct packed {
    logic [6:0] note;
    logic       has_note;
    logic       last;
  } chrd_in_t;

  typedef struct packed {
    kind_e                 kind;
    logic [RootW-1:0]      root_class;
    logic [QualW-1:0]      quality;
    logic [6:0]            bass_note;
    logic                  inverted;
    logic [NumClasses-1:0] class_set;
  } chrd_out_t;

  typedef struct packed {
    logic acc_upd;   // fold the accepted word into the accumulators
    logic root_clr;  // restart the root search
    logic root_inc;  // advance to the next candidate root
    logic finish;    // load the result register and clear the accumulators
  } chrd_cmd_t;

  typedef struct packed {
    logic count_ge2;
    logic match;
    logic root_last;
    logic out_busy;  // result register holds a word that is not taken this cycle
  } chrd_stat_t;

  // Pitch class of a MIDI note: multiply by reciprocal, then one correction.
  function automatic logic [3:0] pitch_class(logic [6:0] n);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  rem;
    prod = 13'(n) * 13'd43;
    q    = prod[12:9];
    rem  = n - (7'(q) * 7'd12);
    if (rem >= 7'd12) begin
      rem = rem - 7'd12;
    end
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/chrd_ctrl.sv =====
// Controller: accepts words, sequences the root search and the result load.
`default_nettype none

module chrd_ctrl
  import chrd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_last_i,
  output logic            in_stall_o,
  input  wire chrd_stat_t stat_i,
  output chrd_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        in_acc;
  logic        done;

  // Stall while searching; hold a closing word until the result register is free.
  assign in_stall_o = (state_q != ST_IDLE) | (in_last_i & stat_i.out_busy);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign done       = ~stat_i.count_ge2 | stat_i.match | stat_i.root_last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_last_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.acc_upd  = in_acc;
        cmd_o.root_clr = in_acc & in_last_i;
      end
      ST_SEARCH: begin
        cmd_o.finish   = done;
        cmd_o.root_inc = ~done;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chrd_datapath.sv =====
// Datapath: note accumulators, root counter, template compare, result register.
`default_nettype none

module chrd_datapath
  import chrd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire chrd_in_t  in_i,
  input  wire chrd_cmd_t cmd_i,
  output chrd_stat_t     stat_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output chrd_out_t      out_o
);

  logic [NumClasses-1:0]   mask_q, mask_d;
  logic [6:0]              low_q, low_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [RootW-1:0]        root_q, root_d;
  logic                    out_valid_q, out_valid_d;
  chrd_out_t               res_q, res_d;
  logic [NumClasses-1:0]   rot;
  logic                    hit;
  logic [QualW-1:0]        hit_idx;
  logic [3:0]              low_pc;

  // Rotate the set so the candidate root sits on bit 0.
  assign rot      = NumClasses'({mask_q, mask_q} >> root_q);
  assign low_pc   = pitch_class(low_q);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int t = 0; t < NumShapes; t++) begin
      if (!hit && rot == CHORD_SHAPES[t]) begin
        hit     = 1'b1;
        hit_idx = QualW'(t);
      end
    end
  end

  assign stat_o.count_ge2 = cnt_q[1];
  assign stat_o.match     = hit & mask_q[root_q];
  assign stat_o.root_last = (root_q == LAST_ROOT);
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

  always_comb begin
    mask_d = mask_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    if (cmd_i.acc_upd && in_i.has_note) begin
      mask_d = mask_q | (NumClasses'(1) << pitch_class(in_i.note));
      if (in_i.note < low_q) begin
        low_d = in_i.note;
      end
      if (!cnt_q[1]) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (cmd_i.finish) begin
      mask_d = '0;
      low_d  = 7'd127;
      cnt_d  = '0;
    end
  end

  always_comb begin
    root_d = root_q;
    if (cmd_i.root_clr) begin
      root_d = '0;
    end else if (cmd_i.root_inc) begin
      root_d = root_q + RootW'(1);
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.finish) begin
      res_d = '0;
      if (cnt_q == 2'd1) begin
        res_d.kind       = KIND_SINGLE;
        res_d.root_class = low_pc;
        res_d.bass_note  = low_q;
        res_d.class_set  = mask_q;
      end else if (cnt_q[1]) begin
        res_d.bass_note = low_q;
        res_d.class_set = mask_q;
        if (stat_o.match) begin
          res_d.kind       = KIND_CHORD;
          res_d.root_class = root_q;
          res_d.quality    = hit_idx;
          res_d.inverted   = (low_pc != root_q);
        end else begin
          res_d.kind = KIND_UNREC;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      low_q       <= 7'd127;
      cnt_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      low_q       <= low_d;
      cnt_q       <= cnt_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/chord_template_recognizer_unit.sv =====
// Chord template recognizer top level: controller plus datapath.
`default_nettype none

// Each accepted note word is folded into a pitch-class set, lowest note
// and a note count that saturates at two. Once a word with last set is
// taken, the input stalls for the search: one candidate root per cycle,
// in ascending pitch-class order, goes through a single rotate-and-compare
// unit against all 13 chord shapes, and the first present root that
// matches wins. Groups of fewer than two notes finish without advancing
// the candidate root. The result lands in an output register, so a new
// group can be collected while the previous result waits to be taken; a
// closing word is held only while that register is still occupied.
module chord_template_recognizer_unit
  import chrd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire chrd_in_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output chrd_out_t      out_o
);

  chrd_cmd_t  cmd;
  chrd_stat_t stat;

  chrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_i.last),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chrd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_chord_template_recognizer_unit.sv =====
// Self-checking testbench for the chord template recognizer unit.
module tb_chord_template_recognizer_unit
  import chrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 1750;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;

  // Shapes relative to the root, in quality order.
  localparam logic [11:0] SHAPE_SETS [13] = '{
    12'h091, 12'h089, 12'h049, 12'h111, 12'h085, 12'h0A1, 12'h891,
    12'h489, 12'h491, 12'h249, 12'h449, 12'h095, 12'h495
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  chrd_in_t  in_i        = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  chrd_out_t out_o;

  chord_template_recognizer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the accumulators.
  logic [11:0] held_set   = '0;
  logic [6:0]  held_low   = 7'd127;
  int          held_count = 0;

  chrd_out_t   pending_results [$];
  int          err_count   = 0;
  int          words_sent  = 0;
  int          results_got = 0;
  int          kind_seen [4] = '{0, 0, 0, 0};
  logic [12:0] quality_seen = '0;
  int          burst_left  = 0;
  int          cycle_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic chrd_in_t mk_word(input int n, input bit h, input bit l);
    chrd_in_t w;
    w.note     = 7'(n);
    w.has_note = h;
    w.last     = l;
    return w;
  endfunction

  function automatic chrd_out_t classify_group(input logic [11:0] set, input logic [6:0] low,
                                               input int count);
    chrd_out_t   r;
    logic [23:0] spun;
    bit          found;
    int          rc;
    int          t;
    r     = '0;
    found = 1'b0;
    if (count == 1) begin
      r.kind       = KIND_SINGLE;
      r.root_class = 4'(low % 12);
      r.bass_note  = low;
      r.class_set  = set;
    end else if (count >= 2) begin
      r.kind      = KIND_UNREC;
      r.bass_note = low;
      r.class_set = set;
      for (rc = 0; rc < 12; rc++) begin
        if (!found && set[rc]) begin
          // Rotate down so that the candidate root sits on bit 0.
          spun = {set, set} >> rc;
          for (t = 0; t < 13; t++) begin
            if (!found && spun[11:0] == SHAPE_SETS[t]) begin
              found        = 1'b1;
              r.kind       = KIND_CHORD;
              r.root_class = 4'(rc);
              r.quality    = 4'(t);
              r.inverted   = (int'(low % 12) != rc);
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Fold an accepted word into the predictor state; close the group on last.
  task automatic fold_word(input chrd_in_t w);
    chrd_out_t r;
    if (w.has_note) begin
      held_set[w.note % 12] = 1'b1;
      if (w.note < held_low) held_low = w.note;
      if (held_count < 2) held_count++;
    end
    if (w.last) begin
      r = classify_group(held_set, held_low, held_count);
      pending_results = {pending_results, r};
      kind_seen[r.kind]++;
      if (r.kind == KIND_CHORD) quality_seen[r.quality] = 1'b1;
      held_set   = '0;
      held_low   = 7'd127;
      held_count = 0;
    end
  endtask

  // Drive one word and hold it until taken; bursts are separated by random gaps.
  task automatic send_word(input chrd_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    fold_word(w);
  endtask

  task automatic send_notes(input int notes [$]);
    int k;
    for (k = 0; k < notes.size(); k++) begin
      send_word(mk_word(notes[k], 1'b1, k == notes.size() - 1));
    end
  endtask

  task automatic test_empty_groups();
    send_word(mk_word(0, 1'b0, 1'b1));
    send_word(mk_word(127, 1'b0, 1'b0));
    send_word(mk_word(85, 1'b0, 1'b1));
  endtask

  task automatic test_single_notes();
    send_word(mk_word(127, 1'b1, 1'b1));
    send_word(mk_word(0, 1'b1, 1'b0));
    send_word(mk_word(42, 1'b0, 1'b1));
  endtask

  task automatic test_chord_shapes();
    send_notes('{64, 67, 72});          // C major, first inversion
    send_notes('{43, 47, 50, 53, 57});  // G dominant 9th
    send_notes('{68, 60, 64});          // augmented: lowest matching class wins
    send_notes('{63, 57, 60, 66});      // diminished 7th, symmetric
  endtask

  task automatic test_unrecognized();
    send_notes('{48, 60});              // octave pair
    send_notes('{61, 60, 127});         // cluster
  endtask

  // Random groups: mostly real chord voicings, some noise and stray words.
  task automatic test_random_groups();
    int notes [$];
    int choice;
    int root;
    int shape;
    int iv;
    int n;
    int k;
    int j;
    int tmp;
    chrd_in_t w;
    while (words_sent < RandomWords) begin
      notes.delete();
      choice = $urandom_range(0, 9);
      if (choice <= 6) begin
        root  = $urandom_range(0, 11);
        shape = $urandom_range(0, 12);
        for (k = 0; k < 12; k++) begin
          if (SHAPE_SETS[shape][k]) begin
            iv = k + (($urandom_range(0, 3) == 0) ? 12 : 0);
            n  = root + iv;
            notes = {notes, int'(n + 12 * $urandom_range(0, (127 - n) / 12))};
          end
        end
        // Doubled chord tone keeps the set unchanged.
        if ($urandom_range(0, 3) == 0) begin
          n = root + 12 * $urandom_range(0, (127 - root) / 12);
          notes = {notes, n};
        end
      end else if (choice == 7) begin
        tmp = $urandom_range(2, 6);
        for (k = 0; k < tmp; k++) notes = {notes, int'($urandom_range(0, 127))};
      end else if (choice == 8) begin
        notes = {notes, int'($urandom_range(0, 127))};
      end
      for (k = notes.size() - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = notes[k];
        notes[k] = notes[j];
        notes[j] = tmp;
      end
      // Close on the final note or with a separate evaluate-only word.
      tmp = (notes.size() > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < notes.size(); k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(mk_word($urandom_range(0, 127), 1'b0, 1'b0));
        end
        send_word(mk_word(notes[k], 1'b1, tmp && k == notes.size() - 1));
      end
      if (!tmp) send_word(mk_word($urandom_range(0, 127), 1'b0, 1'b1));
    end
  endtask

  // Receiver backpressure: switch between stall styles every so often.
  always @(posedge clk_i) begin
    int unsigned mode_left;
    int unsigned stall_mode;
    if (mode_left == 0) begin
      mode_left  = $urandom_range(40, 200);
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 9) < 6);
      end
      default: begin
        out_stall_i <= ((mode_left % 7) < 3);
      end
    endcase
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    chrd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_got++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(out_o.kind), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_o.kind != want.kind)
          report_mismatch("kind", int'(out_o.kind), int'(want.kind));
        if (out_o.root_class != want.root_class)
          report_mismatch("root_class", int'(out_o.root_class), int'(want.root_class));
        if (out_o.quality != want.quality)
          report_mismatch("quality", int'(out_o.quality), int'(want.quality));
        if (out_o.bass_note != want.bass_note)
          report_mismatch("bass_note", int'(out_o.bass_note), int'(want.bass_note));
        if (out_o.inverted != want.inverted)
          report_mismatch("inverted", int'(out_o.inverted), int'(want.inverted));
        if (out_o.class_set != want.class_set)
          report_mismatch("class_set", int'(out_o.class_set), int'(want.class_set));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_groups();
    test_single_notes();
    test_chord_shapes();
    test_unrecognized();
    test_random_groups();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() > 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    $display("Sent %0d words, checked %0d groups: %0d empty, %0d single, %0d chord, %0d other",
             words_sent, results_got, kind_seen[KIND_NONE], kind_seen[KIND_SINGLE],
             kind_seen[KIND_CHORD], kind_seen[KIND_UNREC]);
    $display("Chord qualities recognized: %0d of 13", $countones(quality_seen));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/chrd_pkg.sv
hw/rtl/chrd_ctrl.sv
hw/rtl/chrd_datapath.sv
hw/rtl/chord_template_recognizer_unit.sv
tb/sv/tb_chord_template_recognizer_unit.sv
